>>> hw/rtl/wbcd_pkg.sv
`default_nettype none

package wbcd_pkg;

    // default sizes of the converted number
    localparam int NUMBER_BITS_DEF = 1024;
    localparam int WORD_BITS_DEF   = 64;

    // fixed stream field widths
    localparam int VALUE_W      = 64;
    localparam int CHUNK_W      = 64;
    localparam int COUNT_W      = 5;
    localparam int CHUNK_DIGITS = 16;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 72;
    localparam int M_PAD_W      = M_TDATA_W - CHUNK_W - COUNT_W;

    // commands from the controller to the datapath
    typedef struct packed {
        logic store;      // write the accepted word into the store
        logic start;      // last word seen, clear digits and arm counters
        logic rd_first;   // read the top loaded word
        logic shift;      // one shift-and-add-3 step
        logic word_next;  // step down to the next lower word, read it
        logic skip;       // drop a leading zero chunk
        logic emit;       // load the top chunk into the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic bit_last;   // current bit is bit 0 of its word
        logic word_last;  // current word is word 0
        logic top_zero;   // top chunk of the digit register is all zero
        logic one_left;   // only one chunk remains
        logic found;      // first significant chunk already emitted
        logic out_free;   // output register can take a chunk
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/wide_binary_to_bcd_converter.sv
// words load one per cycle while the controller is idle; the last word starts the
// shift-and-add-3 over the W words received, one bit per cycle through the
// 320-digit register, then each of the 20 chunks is skipped as a leading zero
// chunk or emitted, one per cycle, emits only while the output register is free;
// no new word is taken until the last chunk is loaded into the output register;
// output stalls add to the emit phase; reset: rst_n asynchronous active low,
// clears counters, state, found flag and valid flag
`default_nettype none

module wide_binary_to_bcd_converter
    import wbcd_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // word requests in, least significant word first
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [63:0] value_word
    input  wire logic                 s_tlast,   // last_word

    // bcd chunk requests out, most significant chunk first
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // [63:0] bcd_chunk, [68:64] digit_count
    output logic                      m_tlast    // last_chunk
);

    cmd_t               cmd;
    status_t            status;
    logic [CHUNK_W-1:0] bcd_chunk;
    logic [COUNT_W-1:0] digit_count;

    // controller: load, read, shift and emit sequencing
    wbcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: word store, digit register with add-3 and output register
    wbcd_datapath #(
        .NUMBER_BITS (NUMBER_BITS),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value_word  (s_tdata[VALUE_W-1:0]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .bcd_chunk   (bcd_chunk),
        .digit_count (digit_count),
        .last_chunk  (m_tlast)
    );

    // pack chunk and digit count, zero pad to whole bytes
    assign m_tdata = {{M_PAD_W{1'b0}}, digit_count, bcd_chunk};

endmodule

`default_nettype wire

>>> hw/rtl/wbcd_ram.sv
`default_nettype none

module wbcd_ram
    import wbcd_pkg::*;
#(
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int DEPTH = NUMBER_BITS_DEF / WORD_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wbcd_ctrl.sv
`default_nettype none

module wbcd_ctrl
    import wbcd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    input  wire logic    s_tlast,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RD    = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.store = accept;
                if (accept && s_tlast)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.bit_last)
                begin
                    if (status.word_last)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.word_next = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.top_zero && !status.found && !status.one_left)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.one_left)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a flagged last word always launches the conversion
    a_start_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> state_reg == ST_RD)
        else $error("last word did not start conversion");

    // the final bit of word 0 ends the conversion
    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT && status.bit_last && status.word_last
        |=> state_reg == ST_EMIT)
        else $error("conversion did not end after bit 0 of word 0");

    // no shift or emit while words are still being taken
    a_no_work_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.shift && !cmd.emit && !cmd.skip)
        else $error("datapath work while idle");

endmodule

`default_nettype wire

>>> hw/rtl/wbcd_datapath.sv
`default_nettype none

module wbcd_datapath
    import wbcd_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [VALUE_W-1:0] value_word,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic      [CHUNK_W-1:0] bcd_chunk,
    output logic      [COUNT_W-1:0] digit_count,
    output logic                    last_chunk
);

    localparam int NUM_WORDS   = NUMBER_BITS / WORD_BITS;
    localparam int MAX_DIGITS  = (NUMBER_BITS * 31) / 100 + 1;
    localparam int NUM_CHUNKS  = (MAX_DIGITS + CHUNK_DIGITS - 1) / CHUNK_DIGITS;
    localparam int DIGIT_SLOTS = NUM_CHUNKS * CHUNK_DIGITS;
    localparam int DIG_W       = DIGIT_SLOTS * 4;
    localparam int AW          = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WL_W        = $clog2(NUM_WORDS + 1);
    localparam int BW          = $clog2(WORD_BITS);
    localparam int CW          = $clog2(NUM_CHUNKS + 1);

    logic [WL_W-1:0]      words_loaded_reg;
    logic [WL_W-1:0]      words_loaded_next;
    logic [AW-1:0]        word_idx_reg;
    logic [AW-1:0]        word_idx_next;
    logic [BW-1:0]        bit_idx_reg;
    logic [BW-1:0]        bit_idx_next;
    logic [CW-1:0]        chunks_left_reg;
    logic [CW-1:0]        chunks_left_next;
    logic                 found_reg;
    logic                 found_next;
    logic [DIG_W-1:0]     digits_reg;
    logic [DIG_W-1:0]     digits_next;
    logic [DIG_W-1:0]     adjusted;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHUNK_W-1:0]   out_chunk_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_last_reg;
    logic                 full;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [CHUNK_W-1:0]   top_chunk;
    logic [COUNT_W-1:0]   top_count;

    assign full = (words_loaded_reg == WL_W'(NUM_WORDS));

    // store writes once full are dropped
    assign ram_we    = cmd.store && !full;
    assign ram_re    = cmd.rd_first || cmd.word_next;
    assign ram_raddr = cmd.word_next ? (word_idx_reg - AW'(1)) : word_idx_reg;

    wbcd_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (words_loaded_reg[AW-1:0]),
        .wdata (value_word[WORD_BITS-1:0]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // add 3 to every digit above 4, all digits at once
    always_comb
    begin
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            if (digits_reg[i*4 +: 4] > 4'd4)
            begin
                adjusted[i*4 +: 4] = digits_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adjusted[i*4 +: 4] = digits_reg[i*4 +: 4];
            end
        end
    end

    assign top_chunk = digits_reg[DIG_W-1 -: CHUNK_W];

    // highest nonzero digit of the top chunk, one digit if all zero
    always_comb
    begin
        top_count = COUNT_W'(1);
        for (int i = 0; i < CHUNK_DIGITS; i++)
        begin
            if (top_chunk[i*4 +: 4] != 4'd0)
            begin
                top_count = COUNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        words_loaded_next = words_loaded_reg;
        word_idx_next     = word_idx_reg;
        bit_idx_next      = bit_idx_reg;
        chunks_left_next  = chunks_left_reg;
        found_next        = found_reg;
        digits_next       = digits_reg;

        if (ram_we)
        begin
            words_loaded_next = words_loaded_reg + WL_W'(1);
        end

        if (cmd.start)
        begin
            words_loaded_next = '0;
            word_idx_next     = full ? AW'(NUM_WORDS - 1) : words_loaded_reg[AW-1:0];
            bit_idx_next      = BW'(WORD_BITS - 1);
            chunks_left_next  = CW'(NUM_CHUNKS);
            found_next        = 1'b0;
            digits_next       = '0;
        end

        if (cmd.shift)
        begin
            digits_next = {adjusted[DIG_W-2:0], ram_rdata[bit_idx_reg]};
            if (bit_idx_reg == '0)
            begin
                bit_idx_next = BW'(WORD_BITS - 1);
            end
            else
            begin
                bit_idx_next = bit_idx_reg - BW'(1);
            end
        end

        if (cmd.word_next)
        begin
            word_idx_next = word_idx_reg - AW'(1);
        end

        if (cmd.skip || cmd.emit)
        begin
            digits_next      = {digits_reg[DIG_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            chunks_left_next = chunks_left_reg - CW'(1);
        end

        if (cmd.emit)
        begin
            found_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_loaded_reg <= '0;
            word_idx_reg     <= '0;
            bit_idx_reg      <= '0;
            chunks_left_reg  <= '0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            words_loaded_reg <= words_loaded_next;
            word_idx_reg     <= word_idx_next;
            bit_idx_reg      <= bit_idx_next;
            chunks_left_reg  <= chunks_left_next;
            found_reg        <= found_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        if (cmd.emit)
        begin
            out_chunk_reg <= top_chunk;
            out_count_reg <= found_reg ? COUNT_W'(CHUNK_DIGITS) : top_count;
            out_last_reg  <= (chunks_left_reg == CW'(1));
        end
    end

    assign status.bit_last  = (bit_idx_reg == '0);
    assign status.word_last = (word_idx_reg == '0);
    assign status.top_zero  = (top_chunk == '0);
    assign status.one_left  = (chunks_left_reg == CW'(1));
    assign status.found     = found_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign bcd_chunk   = out_chunk_reg;
    assign digit_count = out_count_reg;
    assign last_chunk  = out_last_reg;

    // the final remaining chunk goes out flagged as last
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && status.one_left |=> out_valid_reg && out_last_reg)
        else $error("final chunk not flagged last");

    // every chunk after the first significant one is full
    a_full_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && found_reg |=> out_count_reg == COUNT_W'(CHUNK_DIGITS))
        else $error("inner chunk with short digit count");

    // never emit into a busy output register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || out_ready)
        else $error("output register overrun");

endmodule

`default_nettype wire

>>> tb/tb_wide_binary_to_bcd_converter.sv
`timescale 1ns / 100ps

module tb_wide_binary_to_bcd_converter;

    import wbcd_pkg::*;

    // sizes of the converted number as built
    localparam int NUMBER_BITS = NUMBER_BITS_DEF;
    localparam int WORD_BITS   = WORD_BITS_DEF;
    localparam int NUM_WORDS   = NUMBER_BITS / WORD_BITS;
    // 1024 bits need at most 309 digits, kept as 20 chunks of 16
    localparam int MAX_DIGITS  = (NUMBER_BITS * 31) / 100 + 1;
    localparam int NUM_CHUNKS  = (MAX_DIGITS + CHUNK_DIGITS - 1) / CHUNK_DIGITS;
    localparam int DIGIT_SLOTS = NUM_CHUNKS * CHUNK_DIGITS;

    // run length and stall limits
    localparam int WORD_TARGET = 410;
    localparam int IDLE_LIMIT  = 8000;
    localparam int DRAIN_WAIT  = 100;

    // one expected chunk request on the master side
    typedef struct packed {
        logic [CHUNK_W-1:0] chunk;
        logic [COUNT_W-1:0] count;
        logic               last;
    } bcd_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [63:0] value_word
    logic                 s_tlast  = 1'b0; // last_word
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [63:0] bcd_chunk, [68:64] digit_count
    logic                 m_tlast;         // last_chunk

    // predictor state: word store and fill count
    logic [VALUE_W-1:0] word_store [NUM_WORDS];
    int                 words_held;

    // chunks still to come from the block, oldest first
    bcd_result_t expected_chunks [$];
    bcd_result_t got_want;

    // idling switches, changed per test
    bit tx_idle_en  = 1'b1;
    bit rx_stall_en = 1'b1;
    int rx_hold     = 0;
    int idle_cycles = 0;

    // run statistics
    int fail_count       = 0;
    int words_sent       = 0;
    int numbers_sent     = 0;
    int overflow_numbers = 0;
    int chunks_checked   = 0;
    int max_chunk_run    = 0;

    wide_binary_to_bcd_converter #(
        .NUMBER_BITS (NUMBER_BITS),
        .WORD_BITS   (WORD_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // take one accepted word; on the last word run shift-and-add-3 over the
    // held number and queue its chunks, most significant first
    function automatic void predict_word(input logic [VALUE_W-1:0] word,
                                         input logic last);
        bit [3:0]             digit [DIGIT_SLOTS];
        bit [NUMBER_BITS-1:0] value;
        bit [4:0]             nd;
        bit                   carry;
        int                   w, b, i, j, k;
        int                   top_bit, shifted, active;
        int                   top_digit, num_digits, num_chunks;
        bcd_result_t          res;

        // words past a full store are dropped, last flag still counts
        if (words_held < NUM_WORDS)
        begin
            word_store[words_held] = word;
            words_held++;
        end
        if (!last)
            return;

        // missing high words read as zero, stale entries never used
        value = '0;
        for (w = 0; w < words_held; w++)
            value[w*WORD_BITS +: WORD_BITS] = word_store[w][WORD_BITS-1:0];
        words_held = 0;

        foreach (digit[i])
            digit[i] = 4'd0;

        // leading zero bits leave the digit register at zero, start at top bit
        top_bit = -1;
        for (b = NUMBER_BITS - 1; b >= 0; b--)
            if (value[b])
            begin
                top_bit = b;
                break;
            end

        shifted = 0;
        for (b = top_bit; b >= 0; b--)
        begin
            // only digits that can be nonzero after this shift need work
            shifted++;
            active = (shifted * 31) / 100 + 2;
            if (active > DIGIT_SLOTS)
                active = DIGIT_SLOTS;
            for (i = 0; i < active; i++)
                if (digit[i] > 4'd4)
                    digit[i] = digit[i] + 4'd3;
            carry = value[b];
            for (i = 0; i < active; i++)
            begin
                nd       = {digit[i], carry};
                carry    = nd[4];
                digit[i] = nd[3:0];
            end
        end

        // leading zero suppression, zero still gives one digit
        top_digit = 0;
        for (j = DIGIT_SLOTS - 1; j >= 0; j--)
            if (digit[j] != 4'd0)
            begin
                top_digit = j;
                break;
            end
        num_digits = top_digit + 1;
        num_chunks = (num_digits + CHUNK_DIGITS - 1) / CHUNK_DIGITS;

        for (k = num_chunks - 1; k >= 0; k--)
        begin
            res.chunk = '0;
            for (j = 0; j < CHUNK_DIGITS; j++)
                res.chunk[j*4 +: 4] = digit[k*CHUNK_DIGITS + j];
            if (k == num_chunks - 1)
                res.count = COUNT_W'(num_digits - k * CHUNK_DIGITS);
            else
                res.count = COUNT_W'(CHUNK_DIGITS);
            res.last = (k == 0);
            expected_chunks.push_back(res);
        end
        if (num_chunks > max_chunk_run)
            max_chunk_run = num_chunks;
        numbers_sent++;
    endfunction

    // send one word request, wait for the handshake, then predict it
    task automatic send_word(input logic [VALUE_W-1:0] word, input logic last);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        predict_word(word, last);
    endtask

    // zero value gives a single digit 0
    task automatic test_zero_value();
        send_word('0, 1'b1);
    endtask

    // one-word numbers at the field extremes
    task automatic test_single_words();
        send_word(64'd1, 1'b1);
        send_word({VALUE_W{1'b1}}, 1'b1);
    endtask

    // exactly 16 digits, then 17 digits split over two chunks
    task automatic test_chunk_boundary();
        send_word(64'd9999999999999999, 1'b1);
        send_word(64'd10000000000000000, 1'b1);
    endtask

    // largest number: every word all ones, 309 digits in 20 chunks
    task automatic test_full_width();
        int w;
        for (w = 0; w < NUM_WORDS; w++)
            send_word({VALUE_W{1'b1}}, w == NUM_WORDS - 1);
    endtask

    // short number after a full one, high word given as zero
    task automatic test_short_number();
        send_word(64'h8000_0000_0000_0001, 1'b0);
        send_word('0, 1'b1);
    endtask

    // random numbers of random length, with some overfilled ones
    task automatic test_random_frames();
        int          n_words, w, r;
        logic [63:0] word;
        while (words_sent < WORD_TARGET)
        begin
            // some numbers run without any idling on either side
            r           = $urandom_range(0, 99);
            tx_idle_en  = (r >= 20);
            rx_stall_en = (r >= 20);

            r = $urandom_range(0, 99);
            if (r < 45)
                n_words = $urandom_range(1, 4);
            else if (r < 88)
                n_words = $urandom_range(1, NUM_WORDS);
            else
            begin
                // words past the store size are dropped by the block
                n_words = $urandom_range(NUM_WORDS + 1, NUM_WORDS + 4);
                overflow_numbers++;
            end

            for (w = 0; w < n_words; w++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    word = {$urandom, $urandom};
                else if (r < 75)
                    word = '0;
                else if (r < 85)
                    word = {VALUE_W{1'b1}};
                else
                    word = 64'($urandom_range(0, 99));
                send_word(word, w == n_words - 1);
            end
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // receiver side: random stalls on m_tready
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rx_stall_en && $urandom_range(0, 99) < 25)
                rx_hold = pick_gap() + 1;
        end
    end

    // chunk checker: every accepted chunk against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chunks.size() == 0)
            begin
                $error("m_tdata: no chunk expected, got %h (m_tlast %b)", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                got_want = expected_chunks.pop_front();
                chunks_checked++;
                if (m_tdata[CHUNK_W-1:0] !== got_want.chunk)
                begin
                    $error("bcd_chunk: expected %h, got %h",
                           got_want.chunk, m_tdata[CHUNK_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[CHUNK_W +: COUNT_W] !== got_want.count)
                begin
                    $error("digit_count: expected %0d, got %0d",
                           got_want.count, m_tdata[CHUNK_W +: COUNT_W]);
                    fail_count++;
                end
                if (m_tlast !== got_want.last)
                begin
                    $error("last_chunk: expected %b, got %b", got_want.last, m_tlast);
                    fail_count++;
                end
                // padding above digit_count stays zero
                if (m_tdata[M_TDATA_W-1:CHUNK_W+COUNT_W] !== '0)
                begin
                    $error("tdata padding: expected %h, got %h", {M_PAD_W{1'b0}},
                           m_tdata[M_TDATA_W-1:CHUNK_W+COUNT_W]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long with no request moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles with no request accepted", IDLE_LIMIT);
            $display("[wide_binary_to_bcd_converter] ERROR");
            $finish;
        end
    end

    initial
    begin
        words_held = 0;

        // single reset at start of run
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_value();
        test_single_words();
        test_chunk_boundary();
        test_full_width();
        test_short_number();
        test_random_frames();

        // stop sending, let every expected chunk arrive, then watch for strays
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d words in %0d numbers (%0d overfilled), up to %0d chunks each",
                 words_sent, numbers_sent, overflow_numbers, max_chunk_run);
        $display("checked %0d bcd chunks, %0d mismatches", chunks_checked, fail_count);
        if (fail_count == 0)
            $display("[wide_binary_to_bcd_converter] OK");
        else
            $display("[wide_binary_to_bcd_converter] ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/wbcd_pkg.sv
hw/rtl/wbcd_ram.sv
hw/rtl/wbcd_ctrl.sv
hw/rtl/wbcd_datapath.sv
hw/rtl/wide_binary_to_bcd_converter.sv
tb/tb_wide_binary_to_bcd_converter.sv
